// File: hw/rtl/distance_signature_point_matcher_defines.svh
// ----------------------------------------------------------------------------
// Distance signature point matcher: assertion macros
// Shared concurrent assertion shorthands, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_SIGNATURE_POINT_MATCHER_DEFINES_SVH
`define DISTANCE_SIGNATURE_POINT_MATCHER_DEFINES_SVH

// Condition holds at every edge
`define DSPM_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence holds on the edge after the trigger
`define DSPM_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dspm_pkg.sv
// ----------------------------------------------------------------------------
// dspm_pkg
// Types, widths and codes shared by the distance signature point matcher.
// ----------------------------------------------------------------------------
package dspm_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int COORD_W        = 24;
  localparam int DIST_W         = 26;
  localparam int TOL_W          = 26;
  localparam int PC_W           = 4;
  localparam int SLOT_W         = 3;
  localparam int SQ_IN_W        = 52;
  localparam int SQRT_STEPS     = 26;
  localparam logic [PC_W-1:0] PC_RESET  = 4'd6;
  localparam logic [TOL_W-1:0] TOL_RESET = 26'd240;

  typedef enum logic [1:0] {
    KIND_LOAD_SRC = 2'd0,
    KIND_LOAD_TGT = 2'd1,
    KIND_RUN      = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_POINT_COUNT = 2'd0,
    CFG_MATCH_TOL   = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    B_IDLE, B_FETCH_I, B_LATCH_I, B_FETCH_J, B_MUL, B_ACC, B_ROOT, B_WAIT, B_WRITE
  } build_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_READ, C_SQ, C_ACC, C_EMIT
  } cmp_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // One signature word written from the builder into the signature store
  typedef struct packed {
    logic              valid;
    logic              target;
    logic [SLOT_W-1:0] row;
    logic [SLOT_W-1:0] col;
    logic [DIST_W-1:0] data;
  } sig_wr_t;

endpackage

// File: hw/rtl/dspm_sqrt.sv
// ----------------------------------------------------------------------------
// dspm_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dspm_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dspm_pkg::SQ_IN_W-1:0]     radicand,
  output logic                             done,
  output logic [dspm_pkg::DIST_W-1:0]      root
);

  localparam int STEP_W = $clog2(dspm_pkg::SQRT_STEPS + 1);

  logic                         busy;
  logic [dspm_pkg::SQ_IN_W-1:0] rem;
  logic [dspm_pkg::SQ_IN_W-1:0] res;
  logic [dspm_pkg::SQ_IN_W-1:0] bitv;
  logic [dspm_pkg::SQ_IN_W-1:0] trial;
  logic [STEP_W-1:0]            step;

  assign trial = res + bitv;
  assign root  = res[dspm_pkg::DIST_W-1:0];

  // Step the restoring root one bit pair per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= '0;
        bitv <= dspm_pkg::SQ_IN_W'(1) << (2 * (dspm_pkg::SQRT_STEPS - 1));
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        step <= step + STEP_W'(1);
        if (step == STEP_W'(dspm_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/dspm_build.sv
// ----------------------------------------------------------------------------
// dspm_build
// Point store and signature builder: pairwise distances, root, sorted rows.
// ----------------------------------------------------------------------------
module dspm_build #(
  parameter int MAX_POINTS = dspm_pkg::MAX_POINTS_DEF,
  localparam int IDX_W     = $clog2(MAX_POINTS),
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_en,
  input  logic                load_target,
  input  logic [IDX_W-1:0]    load_slot,
  input  dspm_pkg::point_t    load_point,
  input  logic                start,
  input  logic [CNT_W-1:0]    n,
  output logic                busy,
  output logic                done,
  output dspm_pkg::sig_wr_t   sig_wr
);

  localparam int DEPTH = 2 ** (IDX_W + 1);
  localparam int DIFF_W = dspm_pkg::COORD_W + 1;

  dspm_pkg::build_state_t state, state_next;

  dspm_pkg::point_t coord_mem [DEPTH];
  dspm_pkg::point_t rd_q;
  dspm_pkg::point_t pi;
  logic             rd_en;
  logic [IDX_W:0]   rd_addr;

  logic             cloud;
  logic [CNT_W-1:0] i, j, k;
  logic [1:0]       axis;

  logic signed [dspm_pkg::COORD_W-1:0] a_sel, b_sel;
  logic signed [DIFF_W-1:0]            diff;
  logic [DIFF_W-1:0]                   mag;
  logic [2*DIFF_W-1:0]                 prod;
  logic [dspm_pkg::SQ_IN_W-1:0]        acc;

  logic [dspm_pkg::DIST_W-1:0] row     [MAX_POINTS];
  logic [dspm_pkg::DIST_W-1:0] row_ins [MAX_POINTS];

  logic                        sqrt_start, sqrt_done;
  logic [dspm_pkg::DIST_W-1:0] root;

  dspm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (acc),
    .done     (sqrt_done),
    .root     (root)
  );

  // Point store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (load_en) begin
      coord_mem[{load_target, load_slot}] <= load_point;
    end
    if (rd_en) begin
      rd_q <= coord_mem[rd_addr];
    end
  end

  // Absolute difference on the selected axis
  always_comb begin
    case (axis)
      2'd0:    begin a_sel = pi.x; b_sel = rd_q.x; end
      2'd1:    begin a_sel = pi.y; b_sel = rd_q.y; end
      default: begin a_sel = pi.z; b_sel = rd_q.z; end
    endcase
    diff = {a_sel[dspm_pkg::COORD_W-1], a_sel} - {b_sel[dspm_pkg::COORD_W-1], b_sel};
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // Insert the new root into the descending row
  always_comb begin
    for (int p = 0; p < MAX_POINTS; p++) begin
      if (row[p] >= root) begin
        row_ins[p] = row[p];
      end else if (p == 0) begin
        row_ins[p] = root;
      end else if (row[(p == 0) ? 0 : p - 1] >= root) begin
        row_ins[p] = root;
      end else begin
        row_ins[p] = row[(p == 0) ? 0 : p - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dspm_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the builder
  always_comb begin
    state_next    = state;
    rd_en         = 1'b0;
    rd_addr       = {cloud, i[IDX_W-1:0]};
    sqrt_start    = 1'b0;
    done          = 1'b0;
    sig_wr.valid  = 1'b0;
    sig_wr.target = cloud;
    sig_wr.row    = dspm_pkg::SLOT_W'(i[IDX_W-1:0]);
    sig_wr.col    = dspm_pkg::SLOT_W'(k[IDX_W-1:0]);
    sig_wr.data   = row[k[IDX_W-1:0]];
    case (state)
      dspm_pkg::B_IDLE: begin
        if (start) state_next = dspm_pkg::B_FETCH_I;
      end
      dspm_pkg::B_FETCH_I: begin
        rd_en      = 1'b1;
        state_next = dspm_pkg::B_LATCH_I;
      end
      dspm_pkg::B_LATCH_I: begin
        state_next = dspm_pkg::B_FETCH_J;
      end
      dspm_pkg::B_FETCH_J: begin
        rd_en      = 1'b1;
        rd_addr    = {cloud, j[IDX_W-1:0]};
        state_next = dspm_pkg::B_MUL;
      end
      dspm_pkg::B_MUL: begin
        if (axis == 2'd2) state_next = dspm_pkg::B_ACC;
      end
      dspm_pkg::B_ACC: begin
        state_next = dspm_pkg::B_ROOT;
      end
      dspm_pkg::B_ROOT: begin
        sqrt_start = 1'b1;
        state_next = dspm_pkg::B_WAIT;
      end
      dspm_pkg::B_WAIT: begin
        if (sqrt_done) begin
          state_next = (j == n - CNT_W'(1)) ? dspm_pkg::B_WRITE : dspm_pkg::B_FETCH_J;
        end
      end
      dspm_pkg::B_WRITE: begin
        sig_wr.valid = 1'b1;
        if (k == n - CNT_W'(1)) begin
          if (i == n - CNT_W'(1) && cloud) begin
            done       = 1'b1;
            state_next = dspm_pkg::B_IDLE;
          end else begin
            state_next = dspm_pkg::B_FETCH_I;
          end
        end
      end
      default: state_next = dspm_pkg::B_IDLE;
    endcase
  end

  assign busy = (state != dspm_pkg::B_IDLE);

  // Datapath registers and loop counters
  always_ff @(posedge clk) begin
    case (state)
      dspm_pkg::B_IDLE: begin
        cloud <= 1'b0;
        i     <= '0;
      end
      dspm_pkg::B_LATCH_I: begin
        pi <= rd_q;
        j  <= '0;
        for (int p = 0; p < MAX_POINTS; p++) row[p] <= '0;
      end
      dspm_pkg::B_FETCH_J: begin
        axis <= 2'd0;
      end
      dspm_pkg::B_MUL: begin
        prod <= mag * mag;
        acc  <= (axis == 2'd0) ? '0 : acc + dspm_pkg::SQ_IN_W'(prod);
        axis <= axis + 2'd1;
      end
      dspm_pkg::B_ACC: begin
        acc <= acc + dspm_pkg::SQ_IN_W'(prod);
      end
      dspm_pkg::B_WAIT: begin
        if (sqrt_done) begin
          row <= row_ins;
          j   <= j + CNT_W'(1);
          k   <= '0;
        end
      end
      dspm_pkg::B_WRITE: begin
        k <= k + CNT_W'(1);
        if (k == n - CNT_W'(1)) begin
          if (i == n - CNT_W'(1)) begin
            i     <= '0;
            cloud <= 1'b1;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/dspm_compare.sv
// ----------------------------------------------------------------------------
// dspm_compare
// Signature store and pair comparer: summed squared difference vs tolerance.
// ----------------------------------------------------------------------------
module dspm_compare #(
  parameter int MAX_POINTS = dspm_pkg::MAX_POINTS_DEF,
  localparam int IDX_W     = $clog2(MAX_POINTS),
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dspm_pkg::sig_wr_t               sig_wr,
  input  logic                            start,
  input  logic [CNT_W-1:0]                n,
  input  logic [dspm_pkg::TOL_W-1:0]      tol,
  output logic                            busy,
  output logic                            done,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dspm_pkg::SLOT_W-1:0]     target_index,
  output logic [dspm_pkg::SLOT_W-1:0]     source_index,
  output logic                            matched,
  output logic                            last
);

  localparam int DEPTH  = 2 ** (2 * IDX_W + 1);
  localparam int DW     = dspm_pkg::DIST_W;
  localparam int ACC_W  = 2 * DW + IDX_W;

  dspm_pkg::cmp_state_t state, state_next;

  logic [DW-1:0]    sig_mem [DEPTH];
  logic [DW-1:0]    t_q, s_q;
  logic             rd_en;
  logic [CNT_W-1:0] t, s, k;

  logic signed [DW:0] diff;
  logic [DW-1:0]      mag;
  logic [2*DW-1:0]    sq;
  logic [2*DW-1:0]    tol2;
  logic [ACC_W-1:0]   acc;
  logic               emit;
  logic               pair_last;

  // Signature store: builder write port, two registered read ports
  always_ff @(posedge clk) begin
    if (sig_wr.valid) begin
      sig_mem[{sig_wr.target, sig_wr.row[IDX_W-1:0], sig_wr.col[IDX_W-1:0]}] <= sig_wr.data;
    end
    if (rd_en) begin
      t_q <= sig_mem[{1'b1, t[IDX_W-1:0], k[IDX_W-1:0]}];
      s_q <= sig_mem[{1'b0, s[IDX_W-1:0], k[IDX_W-1:0]}];
    end
  end

  assign diff = {1'b0, t_q} - {1'b0, s_q};
  assign mag  = diff[DW] ? DW'(-diff) : DW'(diff);
  assign pair_last = (t == n - CNT_W'(1)) && (s == n - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dspm_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the comparer
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    emit       = 1'b0;
    done       = 1'b0;
    case (state)
      dspm_pkg::C_IDLE: begin
        if (start) state_next = dspm_pkg::C_READ;
      end
      dspm_pkg::C_READ: begin
        rd_en      = 1'b1;
        state_next = dspm_pkg::C_SQ;
      end
      dspm_pkg::C_SQ: begin
        state_next = dspm_pkg::C_ACC;
      end
      dspm_pkg::C_ACC: begin
        state_next = (k == n - CNT_W'(1)) ? dspm_pkg::C_EMIT : dspm_pkg::C_READ;
      end
      dspm_pkg::C_EMIT: begin
        if (!out_valid || out_ready) begin
          emit = 1'b1;
          if (pair_last) begin
            done       = 1'b1;
            state_next = dspm_pkg::C_IDLE;
          end else begin
            state_next = dspm_pkg::C_READ;
          end
        end
      end
      default: state_next = dspm_pkg::C_IDLE;
    endcase
  end

  assign busy = (state != dspm_pkg::C_IDLE);

  // Datapath registers and pair counters
  always_ff @(posedge clk) begin
    case (state)
      dspm_pkg::C_IDLE: begin
        t    <= '0;
        s    <= '0;
        k    <= '0;
        acc  <= '0;
        tol2 <= tol * tol;
      end
      dspm_pkg::C_SQ: begin
        sq <= mag * mag;
      end
      dspm_pkg::C_ACC: begin
        acc <= acc + ACC_W'(sq);
        k   <= k + CNT_W'(1);
      end
      dspm_pkg::C_EMIT: begin
        if (emit) begin
          acc <= '0;
          k   <= '0;
          if (s == n - CNT_W'(1)) begin
            s <= '0;
            t <= t + CNT_W'(1);
          end else begin
            s <= s + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      target_index <= dspm_pkg::SLOT_W'(t[IDX_W-1:0]);
      source_index <= dspm_pkg::SLOT_W'(s[IDX_W-1:0]);
      matched      <= (acc < ACC_W'(tol2));
      last         <= pair_last;
    end
  end

endmodule

// File: hw/rtl/distance_signature_point_matcher.sv
// ----------------------------------------------------------------------------
// distance_signature_point_matcher
// Loads source and target points, builds sorted distance signatures and
// reports the match verdict of every target/source pair.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  in      | sink      | kind, point_index, x_coord, y_coord, z_coord
//  out     | source    | target_index, source_index, matched, last
//  cfg     | sink      | cfg_index, cfg_data (always ready)
//
//  A run builds one distance at a time through the 26-step root unit, and the
//  comparer takes each signature element through read, square and accumulate.
//  in_ready stays low from a run word until its last result is registered.
//  A stalled out channel holds the comparer at its current pair.
//  Reset restores the registers; point and signature stores are not cleared.
// ----------------------------------------------------------------------------
`include "distance_signature_point_matcher_defines.svh"

module distance_signature_point_matcher #(
  parameter int MAX_POINTS = dspm_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic [dspm_pkg::SLOT_W-1:0]         point_index,
  input  logic signed [dspm_pkg::COORD_W-1:0] x_coord,
  input  logic signed [dspm_pkg::COORD_W-1:0] y_coord,
  input  logic signed [dspm_pkg::COORD_W-1:0] z_coord,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dspm_pkg::SLOT_W-1:0]         target_index,
  output logic [dspm_pkg::SLOT_W-1:0]         source_index,
  output logic                                matched,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [dspm_pkg::TOL_W-1:0]          cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [dspm_pkg::PC_W-1:0]  point_count;
  logic [dspm_pkg::TOL_W-1:0] match_tolerance;
  logic                       run_active;
  logic                       in_accept, run_go, load_en;
  logic [CNT_W-1:0]           n;
  dspm_pkg::point_t           load_point;
  dspm_pkg::sig_wr_t          sig_wr;
  logic                       build_busy, build_done, cmp_busy, cmp_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = !run_active;
  assign in_accept = in_valid && in_ready;
  assign run_go    = in_accept && (kind == dspm_pkg::KIND_RUN);
  assign load_en   = in_accept
                  && (kind == dspm_pkg::KIND_LOAD_SRC || kind == dspm_pkg::KIND_LOAD_TGT)
                  && ({1'b0, point_index} < 4'(MAX_POINTS));
  assign load_point = '{x: x_coord, y: y_coord, z: z_coord};

  // Clamp the point count into the supported range
  always_comb begin
    if (point_count < 4'd2) begin
      n = CNT_W'(2);
    end else if (point_count > 4'(MAX_POINTS)) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(point_count);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count     <= dspm_pkg::PC_RESET;
      match_tolerance <= dspm_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dspm_pkg::CFG_POINT_COUNT: point_count     <= cfg_data[dspm_pkg::PC_W-1:0];
        dspm_pkg::CFG_MATCH_TOL:   match_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off input words for the length of a run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
    end else if (run_go) begin
      run_active <= 1'b1;
    end else if (cmp_done) begin
      run_active <= 1'b0;
    end
  end

  dspm_build #(.MAX_POINTS(MAX_POINTS)) u_build (
    .clk         (clk),
    .rst         (rst),
    .load_en     (load_en),
    .load_target (kind == dspm_pkg::KIND_LOAD_TGT),
    .load_slot   (point_index[IDX_W-1:0]),
    .load_point  (load_point),
    .start       (run_go),
    .n           (n),
    .busy        (build_busy),
    .done        (build_done),
    .sig_wr      (sig_wr)
  );

  dspm_compare #(.MAX_POINTS(MAX_POINTS)) u_compare (
    .clk          (clk),
    .rst          (rst),
    .sig_wr       (sig_wr),
    .start        (build_done),
    .n            (n),
    .tol          (match_tolerance),
    .busy         (cmp_busy),
    .done         (cmp_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .target_index (target_index),
    .source_index (source_index),
    .matched      (matched),
    .last         (last)
  );

  // Builder and comparer never work at once
  `DSPM_ASSERT_HOLDS(a_phase_excl, $onehot0({build_busy, cmp_busy}), "builder and comparer overlap")
  // A run word starts the builder
  `DSPM_ASSERT_NEXT(a_run_starts, run_go, build_busy, "run word did not start the builder")
  // Nothing follows the final pair
  `DSPM_ASSERT_NEXT(a_last_final, out_valid && out_ready && last, !out_valid, "result after last pair")

endmodule

// File: bench/dspm_match_checker.sv
// ----------------------------------------------------------------------------
// dspm_match_checker
// Watches the input, output and register channels of the point matcher.
// Mirrors the loaded clouds and both registers, rebuilds the sorted distance
// signatures on every run word, and checks each result word against the
// oldest predicted pair verdict.
// ----------------------------------------------------------------------------
module dspm_match_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic [dspm_pkg::SLOT_W-1:0]         point_index,
  input  logic signed [dspm_pkg::COORD_W-1:0] x_coord,
  input  logic signed [dspm_pkg::COORD_W-1:0] y_coord,
  input  logic signed [dspm_pkg::COORD_W-1:0] z_coord,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [dspm_pkg::SLOT_W-1:0]         target_index,
  input  logic [dspm_pkg::SLOT_W-1:0]         source_index,
  input  logic                                matched,
  input  logic                                last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [dspm_pkg::TOL_W-1:0]          cfg_data,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  runs_seen,
  output int                                  pairs_seen,
  output int                                  hits_seen
);

  localparam int NP = dspm_pkg::MAX_POINTS_DEF;
  localparam int DW = dspm_pkg::DIST_W;

  typedef struct packed {
    logic [dspm_pkg::SLOT_W-1:0] tgt;
    logic [dspm_pkg::SLOT_W-1:0] src;
    logic                        hit;
    logic                        fin;
  } pair_verdict_t;

  // Mirrored state: cloud 0 is the source, cloud 1 the target
  logic signed [dspm_pkg::COORD_W-1:0] cloud [2][NP][3];
  logic [DW-1:0]                       sig   [2][NP][NP];
  logic [dspm_pkg::PC_W-1:0]           pc_reg;
  logic [dspm_pkg::TOL_W-1:0]          tol_reg;
  pair_verdict_t                       verdict_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    runs_seen  = 0;
    pairs_seen = 0;
    hits_seen  = 0;
  end

  // Floor square root, 26 fixed steps
  function automatic logic [DW-1:0] floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << (2 * (dspm_pkg::SQRT_STEPS - 1));
    for (int k = 0; k < dspm_pkg::SQRT_STEPS; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[DW-1:0];
  endfunction

  // Distance rows of one cloud, each sorted largest first
  task automatic build_signatures(input int c, input int n);
    longint          d;
    longint unsigned acc;
    logic [DW-1:0]   v;
    int              k;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int a = 0; a < 3; a++) begin
          d = longint'(cloud[c][i][a]) - longint'(cloud[c][j][a]);
          acc += longint'(d * d);
        end
        sig[c][i][j] = floor_root(acc);
      end
      for (int j = 1; j < n; j++) begin
        v = sig[c][i][j];
        k = j;
        while (k > 0 && sig[c][i][k-1] < v) begin
          sig[c][i][k] = sig[c][i][k-1];
          k--;
        end
        sig[c][i][k] = v;
      end
    end
  endtask

  // Predict every target/source verdict of one run
  task automatic predict_run();
    int              n;
    longint          d;
    longint unsigned acc;
    longint unsigned tol2;
    pair_verdict_t   pv;
    n = (pc_reg < 2) ? 2 : (pc_reg > NP) ? NP : int'(pc_reg);
    build_signatures(0, n);
    build_signatures(1, n);
    tol2 = longint'(tol_reg) * longint'(tol_reg);
    for (int t = 0; t < n; t++) begin
      for (int s = 0; s < n; s++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          d = longint'(sig[1][t][k]) - longint'(sig[0][s][k]);
          acc += longint'(d * d);
        end
        pv.tgt = dspm_pkg::SLOT_W'(t);
        pv.src = dspm_pkg::SLOT_W'(s);
        pv.hit = (acc < tol2);
        pv.fin = (t == n - 1) && (s == n - 1);
        verdict_q = {verdict_q, pv};
      end
    end
  endtask

  always @(posedge clk) begin
    pair_verdict_t want;
    if (rst) begin
      pc_reg  = dspm_pkg::PC_RESET;
      tol_reg = dspm_pkg::TOL_RESET;
      verdict_q.delete();
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dspm_pkg::CFG_POINT_COUNT)
          pc_reg = cfg_data[dspm_pkg::PC_W-1:0];
        else if (cfg_index == dspm_pkg::CFG_MATCH_TOL)
          tol_reg = cfg_data;
      end
      // Accepted input words
      if (in_valid && in_ready) begin
        if (kind == dspm_pkg::KIND_LOAD_SRC || kind == dspm_pkg::KIND_LOAD_TGT) begin
          cloud[kind == dspm_pkg::KIND_LOAD_TGT][point_index][0] = x_coord;
          cloud[kind == dspm_pkg::KIND_LOAD_TGT][point_index][1] = y_coord;
          cloud[kind == dspm_pkg::KIND_LOAD_TGT][point_index][2] = z_coord;
        end else if (kind == dspm_pkg::KIND_RUN) begin
          predict_run();
          runs_seen++;
        end
      end
      // Accepted result words
      if (out_valid && out_ready) begin
        pairs_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: tgt %0d src %0d matched %0b last %0b",
                     target_index, source_index, matched, last);
        end else begin
          want = verdict_q.pop_front();
          if (want.hit) hits_seen++;
          if (target_index !== want.tgt || source_index !== want.src ||
              matched !== want.hit || last !== want.fin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp tgt %0d src %0d m %0b l %0b, %s",
                       want.tgt, want.src, want.hit, want.fin,
                       $sformatf("got tgt %0d src %0d m %0b l %0b",
                                 target_index, source_index, matched, last));
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// File: bench/tb_distance_signature_point_matcher.sv
// ----------------------------------------------------------------------------
// tb_distance_signature_point_matcher
// Drives point loads, run words and register writes into the matcher with
// bursty input and a stalling output, and leaves prediction and checking to
// the checker beside it. Covers extreme coordinates, point counts that clamp
// at both ends, zero and full tolerance, and clouds that are noisy permutations.
// ----------------------------------------------------------------------------
module tb_distance_signature_point_matcher;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int         N_PHASES   = 8;
  localparam int         NP         = dspm_pkg::MAX_POINTS_DEF;
  localparam int         CW         = dspm_pkg::COORD_W;
  localparam int         TW         = dspm_pkg::TOL_W;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                kind;
  logic [dspm_pkg::SLOT_W-1:0] point_index;
  logic signed [CW-1:0]      x_coord;
  logic signed [CW-1:0]      y_coord;
  logic signed [CW-1:0]      z_coord;
  logic                      out_valid;
  logic                      out_ready;
  logic [dspm_pkg::SLOT_W-1:0] target_index;
  logic [dspm_pkg::SLOT_W-1:0] source_index;
  logic                      matched;
  logic                      last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [TW-1:0]             cfg_data;

  int mismatches;
  int pending;
  int runs_seen;
  int pairs_seen;
  int hits_seen;

  int   words_sent;
  int   burst_left;
  int   eff_n;
  bit   hold_req;
  logic signed [CW-1:0] src_pt [NP][3];

  logic [dspm_pkg::PC_W-1:0] phase_pc [N_PHASES] = '{4'd2, 4'd3, 4'd0, 4'd4, 4'd1, 4'd5,
                                                    4'd8, 4'd7};
  logic [TW-1:0] phase_tol [N_PHASES] = '{26'h3FFFFFF, 26'd64, 26'd200, 26'd1000,
                                          26'd16, 26'd300, 26'd5000, 26'd240};

  distance_signature_point_matcher u_top (.*);

  dspm_match_checker u_check (.*);

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard limit on the run
  initial begin
    #6000000;
    $display("tb_distance_signature_point_matcher: errors");
    $finish;
  end

  // Receiver: shifting stall pattern, with a long hold-off on request
  initial begin
    int stall_phase;
    stall_phase = 0;
    out_ready   = 1'b0;
    hold_req    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        stall_phase++;
        case (stall_phase[9:8])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= 1'($urandom_range(0, 1));
          2'd2:    out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= stall_phase[2];
        endcase
      end
    end
  end

  function automatic logic signed [CW-1:0] rand_coord(bit wide);
    if (wide) return CW'($urandom);
    return CW'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  // Offer one word; idle between bursts
  task automatic send_word(logic [1:0] k, int slot, logic signed [CW-1:0] xv,
                           logic signed [CW-1:0] yv, logic signed [CW-1:0] zv);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    point_index <= dspm_pkg::SLOT_W'(slot);
    x_coord     <= xv;
    y_coord     <= yv;
    z_coord     <= zv;
    burst_left--;
    words_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering until every predicted verdict has arrived
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(dspm_pkg::cfg_reg_t idx, logic [TW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load n source points, then a target cloud that is mostly a noisy permutation
  task automatic load_clouds(int n, bit wide);
    int perm [NP];
    int tmp;
    int r;
    bit mimic;
    for (int i = 0; i < n; i++) begin
      for (int a = 0; a < 3; a++) src_pt[i][a] = rand_coord(wide);
      send_word(dspm_pkg::KIND_LOAD_SRC, i, src_pt[i][0], src_pt[i][1], src_pt[i][2]);
    end
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      r = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[r];
      perm[r] = tmp;
    end
    mimic = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < n; i++) begin
      if (mimic)
        send_word(dspm_pkg::KIND_LOAD_TGT, perm[i],
                  src_pt[i][0] + CW'(int'($urandom_range(0, 2)) - 1),
                  src_pt[i][1] + CW'(int'($urandom_range(0, 2)) - 1),
                  src_pt[i][2] + CW'(int'($urandom_range(0, 2)) - 1));
      else
        send_word(dspm_pkg::KIND_LOAD_TGT, perm[i], rand_coord(wide), rand_coord(wide),
                  rand_coord(wide));
    end
    if ($urandom_range(0, 5) == 0)
      send_word(KIND_SPARE, $urandom_range(0, 7), rand_coord(1), rand_coord(1),
                rand_coord(1));
  endtask

  // Stimulus
  initial begin
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] pts [NP][3];
    int phase_goal;
    hi = {1'b0, {(CW-1){1'b1}}};
    lo = {1'b1, {(CW-1){1'b0}}};
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = dspm_pkg::KIND_LOAD_SRC;
    point_index = '0;
    x_coord     = '0;
    y_coord     = '0;
    z_coord     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = dspm_pkg::CFG_POINT_COUNT;
    cfg_data    = '0;
    words_sent  = 0;
    burst_left  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes in slots 0 to 3 of both clouds, identical clouds
    for (int i = 0; i < NP; i++)
      for (int a = 0; a < 3; a++) pts[i][a] = rand_coord(1);
    pts[0] = '{hi, hi, hi};
    pts[1] = '{lo, lo, lo};
    pts[2] = '{'0, '0, '0};
    pts[3] = '{hi, lo, '0};
    for (int i = 0; i < NP; i++)
      send_word(dspm_pkg::KIND_LOAD_SRC, i, pts[i][0], pts[i][1], pts[i][2]);
    for (int i = 0; i < NP; i++)
      send_word(dspm_pkg::KIND_LOAD_TGT, i, pts[i][0], pts[i][1], pts[i][2]);
    send_word(dspm_pkg::KIND_RUN, 0, '0, '0, '0);
    send_word(KIND_SPARE, 7, hi, lo, hi);
    drain();
    // Clamped high point count, zero tolerance
    write_reg(dspm_pkg::CFG_POINT_COUNT, 26'd15);
    write_reg(dspm_pkg::CFG_MATCH_TOL, '0);
    send_word(dspm_pkg::KIND_RUN, 0, '0, '0, '0);
    drain();

    // Random phases of well-formed load/run sequences
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(dspm_pkg::CFG_POINT_COUNT, TW'(phase_pc[ph]));
      write_reg(dspm_pkg::CFG_MATCH_TOL, phase_tol[ph]);
      eff_n = (phase_pc[ph] < 2) ? 2 : (phase_pc[ph] > NP) ? NP : int'(phase_pc[ph]);
      phase_goal = words_sent + ((ph == 3) ? 15 : 9);
      while (words_sent < phase_goal) begin
        load_clouds(eff_n, $urandom_range(0, 3) == 0);
        // Long output hold-off while the sender keeps offering
        if (ph == 3) hold_req = 1'b1;
        send_word(dspm_pkg::KIND_RUN, $urandom_range(0, 7), rand_coord(1), rand_coord(1),
                  rand_coord(1));
      end
      drain();
    end

    $display("stimulus: %0d words, %0d runs, %0d pairs checked, %0d of them matched",
             words_sent, runs_seen, pairs_seen, hits_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_distance_signature_point_matcher: clean");
    end else begin
      $display("tb_distance_signature_point_matcher: errors");
    end
    $finish;
  end

endmodule
